// ===== rtl/sle_pkg.sv =====
// ============================================================================
// sle_pkg: shared types, scan codes and keymap tables
// Scan-code set 1 constants, result kinds, sequencer states and the
// lower/upper ASCII keymaps used by the line editor.
// ============================================================================
package sle_pkg;

  // Scan codes (set 1)
  localparam logic [7:0] SC_SHIFT_L     = 8'h2A;
  localparam logic [7:0] SC_SHIFT_R     = 8'h36;
  localparam logic [7:0] SC_SHIFT_L_REL = 8'hAA;
  localparam logic [7:0] SC_SHIFT_R_REL = 8'hB6;
  localparam logic [7:0] SC_CAPS        = 8'h3A;
  localparam logic [7:0] SC_BACKSPACE   = 8'h0E;
  localparam logic [7:0] SC_ENTER       = 8'h1C;
  localparam logic [7:0] SC_RIGHT       = 8'h4D;
  localparam logic [7:0] SC_LEFT        = 8'h4B;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_ECHO  = 3'd0,
    KIND_ERASE = 3'd1,
    KIND_LINE  = 3'd2,
    KIND_EMPTY = 3'd3,
    KIND_OVF   = 3'd4
  } kind_t;

  // Decoded key action
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SHIFT_ON,
    ACT_SHIFT_OFF,
    ACT_CAPS,
    ACT_ERASE,
    ACT_ENTER,
    ACT_CHAR
  } act_t;

  typedef struct packed {
    act_t       act;
    logic [6:0] ch;
  } dec_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEC,
    ST_RD,
    ST_SEND
  } state_t;

  function automatic logic [6:0] lower_char(input logic [5:0] idx);
    logic [6:0] c;
    unique case (idx)
      6'd1:  c = 7'd27;
      6'd2:  c = 7'd49;
      6'd3:  c = 7'd50;
      6'd4:  c = 7'd51;
      6'd5:  c = 7'd52;
      6'd6:  c = 7'd53;
      6'd7:  c = 7'd54;
      6'd8:  c = 7'd55;
      6'd9:  c = 7'd56;
      6'd10: c = 7'd57;
      6'd11: c = 7'd48;
      6'd12: c = 7'd45;
      6'd13: c = 7'd61;
      6'd14: c = 7'd8;
      6'd15: c = 7'd9;
      6'd16: c = 7'd113;
      6'd17: c = 7'd119;
      6'd18: c = 7'd101;
      6'd19: c = 7'd114;
      6'd20: c = 7'd116;
      6'd21: c = 7'd121;
      6'd22: c = 7'd117;
      6'd23: c = 7'd105;
      6'd24: c = 7'd111;
      6'd25: c = 7'd112;
      6'd26: c = 7'd91;
      6'd27: c = 7'd93;
      6'd28: c = 7'd10;
      6'd30: c = 7'd97;
      6'd31: c = 7'd115;
      6'd32: c = 7'd100;
      6'd33: c = 7'd102;
      6'd34: c = 7'd103;
      6'd35: c = 7'd104;
      6'd36: c = 7'd106;
      6'd37: c = 7'd107;
      6'd38: c = 7'd108;
      6'd39: c = 7'd59;
      6'd40: c = 7'd39;
      6'd41: c = 7'd96;
      6'd43: c = 7'd92;
      6'd44: c = 7'd122;
      6'd45: c = 7'd120;
      6'd46: c = 7'd99;
      6'd47: c = 7'd118;
      6'd48: c = 7'd98;
      6'd49: c = 7'd110;
      6'd50: c = 7'd109;
      6'd51: c = 7'd44;
      6'd52: c = 7'd46;
      6'd53: c = 7'd47;
      6'd55: c = 7'd42;
      6'd57: c = 7'd32;
      default: c = 7'd0;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] upper_char(input logic [5:0] idx);
    logic [6:0] c;
    unique case (idx)
      6'd1:  c = 7'd27;
      6'd2:  c = 7'd33;
      6'd3:  c = 7'd64;
      6'd4:  c = 7'd35;
      6'd5:  c = 7'd36;
      6'd6:  c = 7'd37;
      6'd7:  c = 7'd94;
      6'd8:  c = 7'd38;
      6'd9:  c = 7'd42;
      6'd10: c = 7'd40;
      6'd11: c = 7'd41;
      6'd12: c = 7'd95;
      6'd13: c = 7'd43;
      6'd14: c = 7'd8;
      6'd15: c = 7'd9;
      6'd16: c = 7'd81;
      6'd17: c = 7'd87;
      6'd18: c = 7'd69;
      6'd19: c = 7'd82;
      6'd20: c = 7'd84;
      6'd21: c = 7'd89;
      6'd22: c = 7'd85;
      6'd23: c = 7'd73;
      6'd24: c = 7'd79;
      6'd25: c = 7'd80;
      6'd26: c = 7'd123;
      6'd27: c = 7'd125;
      6'd28: c = 7'd10;
      6'd30: c = 7'd65;
      6'd31: c = 7'd83;
      6'd32: c = 7'd68;
      6'd33: c = 7'd70;
      6'd34: c = 7'd71;
      6'd35: c = 7'd72;
      6'd36: c = 7'd74;
      6'd37: c = 7'd75;
      6'd38: c = 7'd76;
      6'd39: c = 7'd58;
      6'd40: c = 7'd34;
      6'd41: c = 7'd126;
      6'd43: c = 7'd124;
      6'd44: c = 7'd90;
      6'd45: c = 7'd88;
      6'd46: c = 7'd67;
      6'd47: c = 7'd86;
      6'd48: c = 7'd66;
      6'd49: c = 7'd78;
      6'd50: c = 7'd77;
      6'd51: c = 7'd60;
      6'd52: c = 7'd62;
      6'd53: c = 7'd63;
      6'd55: c = 7'd42;
      6'd57: c = 7'd32;
      default: c = 7'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/sle_key_decode.sv =====
// ============================================================================
// sle_key_decode: scan code classifier
// Maps one scan code plus shift/caps state to a key action and character.
// ============================================================================
module sle_key_decode
  import sle_pkg::*;
(
  input  logic [7:0] code,
  input  logic       shift_held,
  input  logic       caps_on,
  output dec_t       dec
);

  logic [6:0] ch;

  // shift XOR caps picks the upper map; entries past the table read as zero
  assign ch = (shift_held ^ caps_on) ? upper_char(code[5:0]) : lower_char(code[5:0]);

  always_comb begin
    dec.ch = ch;
    priority if (code == SC_SHIFT_L || code == SC_SHIFT_R) begin
      dec.act = ACT_SHIFT_ON;
    end else if (code == SC_SHIFT_L_REL || code == SC_SHIFT_R_REL) begin
      dec.act = ACT_SHIFT_OFF;
    end else if (code == SC_RIGHT || code == SC_LEFT) begin
      dec.act = ACT_NONE;
    end else if (code == SC_CAPS) begin
      dec.act = ACT_CAPS;
    end else if (code == SC_BACKSPACE) begin
      dec.act = ACT_ERASE;
    end else if (code[7]) begin
      dec.act = ACT_NONE;
    end else if (code == SC_ENTER) begin
      dec.act = ACT_ENTER;
    end else if (!code[6] && ch != 7'd0) begin
      dec.act = ACT_CHAR;
    end else begin
      dec.act = ACT_NONE;
    end
  end

endmodule

// ===== rtl/sle_line_ram.sv =====
// ============================================================================
// sle_line_ram: line character store
// One write port, one read port with registered read data.
// ============================================================================
module sle_line_ram #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [6:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [6:0]    rdata
);

  logic [6:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/scancode_line_editor.sv =====
// ============================================================================
// scancode_line_editor: scan-code set 1 to ASCII line editor
// Decodes key presses, keeps a line buffer, echoes, erases and submits lines.
// ============================================================================
// Each request carries one raw set 1 scan code byte. Shift (0x2A/0x36 press,
// 0xAA/0xB6 release) and caps lock (0x3A press toggles) are tracked; shift XOR
// caps selects the upper keymap, symbols included. A printable press is
// written into the line buffer and echoed (kind 0); a press with a full buffer
// is dropped and reported as overflow (kind 4). Backspace (0x0E) removes the
// last character (kind 1), and does nothing on an empty line. Enter (0x1C)
// plays the whole line back one character per result (kind 2, last set on the
// final one) and empties the buffer; an empty line gives one kind 3 result.
// Arrow keys, other releases and unmapped codes give no result. The block
// takes one request at a time and is not ready until it has finished with it;
// a result is held until the consumer takes it. A line submit plays back
// through the single read port of the line buffer: each character is read
// (ST_RD) and then presented (ST_SEND) before the next one is read. No
// clearing pass is needed after reset.
module scancode_line_editor
  import sle_pkg::*;
#(
  parameter int LINE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scan_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [6:0] out_char_code,
  output logic [6:0] out_line_length,
  output logic       out_last
);

  localparam int AW = $clog2(LINE_DEPTH);      // buffer address width
  localparam int FW = $clog2(LINE_DEPTH + 1);  // fill count width (holds DEPTH)

  // length fields are 7 bits wide; wider fill counts wrap to their low 7 bits
  function automatic logic [6:0] to_len(input logic [FW-1:0] v);
    logic [FW+6:0] ext;
    ext = {7'd0, v};
    return ext[6:0];
  endfunction

  state_t        state_r, state_nxt;
  logic [7:0]    code_r, code_nxt;
  logic          shift_r, shift_nxt;
  logic          caps_r, caps_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] idx_r, idx_nxt;
  logic [FW-1:0] idx_inc;
  logic          out_valid_r, out_valid_nxt;
  kind_t         out_kind_r, out_kind_nxt;
  logic [6:0]    out_char_r, out_char_nxt;
  logic [6:0]    out_len_r, out_len_nxt;
  logic          out_last_r, out_last_nxt;

  dec_t          dec;
  logic          line_empty;
  logic          line_full;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [6:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [6:0]    ram_rdata;

  sle_key_decode u_dec (
    .code       (code_r),
    .shift_held (shift_r),
    .caps_on    (caps_r),
    .dec        (dec)
  );

  sle_line_ram #(.DEPTH(LINE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign line_empty = (fill_r == '0);
  assign line_full  = (fill_r == FW'(LINE_DEPTH));
  assign idx_inc    = idx_r + 1'b1;

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_char_code   = out_char_r;
  assign out_line_length = out_len_r;
  assign out_last        = out_last_r;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        unique case (dec.act)
          ACT_ERASE: state_nxt = line_empty ? ST_IDLE : ST_SEND;
          ACT_ENTER: state_nxt = line_empty ? ST_SEND : ST_RD;
          ACT_CHAR:  state_nxt = ST_SEND;
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_RD: state_nxt = ST_SEND;
      ST_SEND: begin
        if (out_ready) begin
          // more line characters to play back: go read the next one
          state_nxt = (out_kind_r == KIND_LINE && !out_last_r) ? ST_RD : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- datapath and outputs ----------------
  always_comb begin
    code_nxt      = code_r;
    shift_nxt     = shift_r;
    caps_nxt      = caps_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_char_nxt  = out_char_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = fill_r[AW-1:0];
    ram_wdata     = dec.ch;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          code_nxt = in_scan_code;
        end
      end
      ST_DEC: begin
        unique case (dec.act)
          ACT_SHIFT_ON:  shift_nxt = 1'b1;
          ACT_SHIFT_OFF: shift_nxt = 1'b0;
          ACT_CAPS:      caps_nxt  = ~caps_r;
          ACT_ERASE: begin
            if (!line_empty) begin
              fill_nxt      = fill_r - 1'b1;
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_ERASE;
              out_char_nxt  = 7'd0;
              out_len_nxt   = to_len(fill_r - 1'b1);
              out_last_nxt  = 1'b1;
            end
          end
          ACT_ENTER: begin
            if (line_empty) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_EMPTY;
              out_char_nxt  = 7'd0;
              out_len_nxt   = 7'd0;
              out_last_nxt  = 1'b1;
            end else begin
              // start playback at entry zero
              idx_nxt   = '0;
              ram_re    = 1'b1;
              ram_raddr = '0;
            end
          end
          ACT_CHAR: begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = dec.ch;
            out_last_nxt  = 1'b1;
            if (line_full) begin
              out_kind_nxt = KIND_OVF;
              out_len_nxt  = to_len(fill_r);
            end else begin
              ram_we       = 1'b1;
              fill_nxt     = fill_r + 1'b1;
              out_kind_nxt = KIND_ECHO;
              out_len_nxt  = to_len(fill_r + 1'b1);
            end
          end
          default: begin
          end
        endcase
      end
      ST_RD: begin
        // read data for idx_r is ready
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_LINE;
        out_char_nxt  = ram_rdata;
        out_len_nxt   = to_len(fill_r);
        out_last_nxt  = (idx_inc == fill_r);
      end
      ST_SEND: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_kind_r == KIND_LINE) begin
            if (out_last_r) begin
              fill_nxt = '0;
            end else begin
              idx_nxt   = idx_inc;
              ram_re    = 1'b1;
              ram_raddr = idx_inc[AW-1:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      shift_r     <= 1'b0;
      caps_r      <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      shift_r     <= shift_nxt;
      caps_r      <= caps_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r     <= code_nxt;
    idx_r      <= idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_char_r <= out_char_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(LINE_DEPTH))
    else $error("line fill exceeds buffer depth");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ready)
    else $error("request accepted while a result is pending");

  a_clear_after_submit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_kind_r == KIND_LINE && out_last_r) |=> fill_r == '0)
    else $error("line not cleared after submit");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> (idx_r < fill_r))
    else $error("playback index past line fill");
`endif

endmodule
